[src/cvl_pkg.sv]
// Shared constants and types for the 3x3 RGB convolution block.
package cvl_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int FW_W      = 11;
  localparam int DIV_W     = 12;
  localparam int KROW_W    = 24;
  localparam int PIX_W     = 24;
  localparam int ACC_W     = 20;  // nine signed 8x8 products fit in 20 bits
  localparam int MAG_W     = ACC_W - 1;
  localparam int STEP_W    = $clog2(MAG_W + 1);
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_KERNEL_TOP    = 3'd2,
    CFG_KERNEL_MIDDLE = 3'd3,
    CFG_KERNEL_BOTTOM = 3'd4,
    CFG_KERNEL_DIV    = 3'd5
  } cfg_idx_t;

  typedef logic [2:0][KROW_W-1:0] kern_t;
  typedef logic [8:0][PIX_W-1:0]  win_t;
  typedef logic [8:0][7:0]        taps_t;

endpackage

[src/cvl_if.sv]
// Pixel channel interfaces: input pixels and tagged result pixels.
interface cvl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface cvl_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_row;
  logic [9:0]  out_column;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        last_of_run;
  modport source (output valid, out_row, out_column, out_red, out_green, out_blue,
                  last_of_run, input ready);
  modport sink   (input valid, out_row, out_column, out_red, out_green, out_blue,
                  last_of_run, output ready);
endinterface

[src/cvl_window.sv]
// Two line stores and the 3x3 window shift registers.
module cvl_window import cvl_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic             shift_en,
  input  logic [COL_W-1:0] rd_addr,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [PIX_W-1:0] pix,
  output win_t             win
);

  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_r;
  logic [PIX_W-1:0] mid_r;
  win_t             win_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      top_r <= older_mem[rd_addr];
      mid_r <= newer_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      older_mem[wr_addr] <= mid_r;
      newer_mem[wr_addr] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      win_r[0] <= win_r[1]; win_r[1] <= win_r[2]; win_r[2] <= top_r;
      win_r[3] <= win_r[4]; win_r[4] <= win_r[5]; win_r[5] <= mid_r;
      win_r[6] <= win_r[7]; win_r[7] <= win_r[8]; win_r[8] <= pix;
    end
  end

  assign win = win_r;

endmodule

[src/cvl_lane.sv]
// One color channel: kernel multiply-accumulate, iterative divide and clamp.
module cvl_lane import cvl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  taps_t            taps,
  input  kern_t            kern,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [7:0]       result
);

  typedef enum logic [1:0] {L_IDLE, L_MAC, L_DIV} lstate_t;

  lstate_t                   state_r;
  logic [1:0]                mac_cnt_r;
  logic [STEP_W-1:0]         div_cnt_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      neg_r;
  logic [DIV_W-1:0]          rem_r;
  logic [MAG_W-1:0]          quo_r;
  logic                      done_r;
  logic [7:0]                result_r;

  logic [KROW_W-1:0]         krow;
  logic [2:0][7:0]           prow;
  logic signed [ACC_W-1:0]   sum3;
  logic signed [ACC_W-1:0]   acc_nxt;
  logic [DIV_W-1:0]          div_eff;
  logic [DIV_W:0]            trial;
  logic                      fits;
  logic [MAG_W-1:0]          quo_nxt;

  always_comb begin
    unique case (mac_cnt_r)
      2'd0:    begin krow = kern[0]; prow = {taps[2], taps[1], taps[0]}; end
      2'd1:    begin krow = kern[1]; prow = {taps[5], taps[4], taps[3]}; end
      default: begin krow = kern[2]; prow = {taps[8], taps[7], taps[6]}; end
    endcase
    sum3 = '0;
    for (int j = 0; j < 3; j++) begin
      sum3 = sum3 + ACC_W'($signed(krow[8*j +: 8]) * $signed({1'b0, prow[j]}));
    end
    acc_nxt = acc_r + sum3;
  end

  assign div_eff = (divisor == '0) ? DIV_W'(1) : divisor;
  assign trial   = {rem_r, quo_r[MAG_W-1]};
  assign fits    = (trial >= {1'b0, div_eff});
  assign quo_nxt = {quo_r[MAG_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == L_DIV) && (div_cnt_r == STEP_W'(MAG_W - 1));
      unique case (state_r)
        L_IDLE: begin
          if (start) begin
            state_r   <= L_MAC;
            mac_cnt_r <= '0;
            acc_r     <= '0;
          end
        end
        L_MAC: begin
          acc_r     <= acc_nxt;
          mac_cnt_r <= mac_cnt_r + 2'd1;
          if (mac_cnt_r == 2'd2) begin
            state_r   <= L_DIV;
            neg_r     <= acc_nxt[ACC_W-1];
            quo_r     <= acc_nxt[ACC_W-1] ? MAG_W'(-acc_nxt) : acc_nxt[MAG_W-1:0];
            rem_r     <= '0;
            div_cnt_r <= '0;
          end
        end
        L_DIV: begin
          rem_r     <= fits ? DIV_W'(trial - {1'b0, div_eff}) : trial[DIV_W-1:0];
          quo_r     <= quo_nxt;
          div_cnt_r <= div_cnt_r + STEP_W'(1);
          if (div_cnt_r == STEP_W'(MAG_W - 1)) begin
            state_r <= L_IDLE;
            // negative quotient clamps to zero
            if (neg_r)                      result_r <= 8'd0;
            else if (quo_nxt > MAG_W'(255)) result_r <= 8'd255;
            else                            result_r <= quo_nxt[7:0];
          end
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

[src/convolve_3x3_rgb.sv]
// A pixel without a filtered result passes through the read and shift states
// and then one emit state per result emitted; a pixel that completes an interior
// window also waits in the calc state for the three channel lanes (kernel
// multiply-accumulate, one kernel row a cycle, then a 19-step restoring divider).
// Output back-pressure stalls the emit states. One pixel is in flight at a time;
// the line stores are single-port memories read when a pixel is taken and
// written in the shift state, after the read state. Border pixels are emitted
// unchanged; an interior result comes first when both occur for one pixel.
module convolve_3x3_rgb import cvl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  cvl_in_if.sink               in_pix,
  cvl_out_if.source            out_pix,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KROW_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_SHIFT, S_CALC, S_EMIT_INT, S_EMIT_BRD} state_t;

  state_t           state_r;
  logic [FW_W-1:0]  fw_r;
  logic [ROW_W-1:0] fh_r;
  kern_t            kern_r;
  logic [DIV_W-1:0] kdiv_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] emit_col_r;
  logic [ROW_W-1:0] emit_row_r;
  logic [PIX_W-1:0] pix_r;
  logic             border_r;

  logic             out_valid_r;
  logic [ROW_W-1:0] o_row_r;
  logic [COL_W-1:0] o_col_r;
  logic [PIX_W-1:0] o_pix_r;
  logic             o_last_r;

  logic [FW_W-1:0]  w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [FW_W-1:0]  col_ext;
  logic             border;
  logic             interior;
  logic             col_end;
  logic             row_end;
  logic             in_acc;
  logic             out_free;
  logic             emitting;
  win_t             win;
  taps_t [2:0]      taps;
  logic [2:0]       lane_done;
  logic [2:0][7:0]  lane_res;

  assign w_eff = (fw_r < FW_W'(3)) ? FW_W'(3) :
                 (fw_r > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_r;
  assign h_eff = (fh_r < ROW_W'(3)) ? ROW_W'(3) : fh_r;
  assign col_ext = FW_W'(col_r);
  assign col_end = (col_ext >= w_eff - FW_W'(1));
  assign row_end = (row_r >= h_eff - ROW_W'(1));
  assign border   = (row_r == '0) || row_end || (col_r == '0) || col_end;
  assign interior = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2)) &&
                    (row_r <= h_eff - ROW_W'(1)) && (col_ext <= w_eff - FW_W'(1));

  assign in_pix.ready = (state_r == S_IDLE);
  assign in_acc       = in_pix.valid && in_pix.ready;
  assign out_free     = !out_valid_r || out_pix.ready;
  assign emitting     = (state_r == S_EMIT_INT) || (state_r == S_EMIT_BRD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= FW_W'(1024);
      fh_r   <= ROW_W'(1024);
      kern_r <= {3{KROW_W'(24'h010101)}};
      kdiv_r <= DIV_W'(9);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:   fw_r      <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT:  fh_r      <= cfg_data[ROW_W-1:0];
        CFG_KERNEL_TOP:    kern_r[0] <= cfg_data;
        CFG_KERNEL_MIDDLE: kern_r[1] <= cfg_data;
        CFG_KERNEL_BOTTOM: kern_r[2] <= cfg_data;
        CFG_KERNEL_DIV:    kdiv_r    <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  cvl_window u_window (
    .clk      (clk),
    .rd_en    (in_acc),
    .shift_en (state_r == S_SHIFT),
    .rd_addr  (col_r),
    .wr_addr  (col_r),
    .pix      (pix_r),
    .win      (win)
  );

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    for (genvar t = 0; t < 9; t++) begin : g_tap
      assign taps[ch][t] = win[t][8*ch +: 8];
    end
    cvl_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   ((state_r == S_SHIFT) && interior),
      .taps    (taps[ch]),
      .kern    (kern_r),
      .divisor (kdiv_r),
      .done    (lane_done[ch]),
      .result  (lane_res[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // an emit state reloads the output register itself
      if (out_valid_r && out_pix.ready && !emitting) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pix_r   <= {in_pix.in_blue, in_pix.in_green, in_pix.in_red};
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_SHIFT;
        S_SHIFT: begin
          border_r   <= border;
          emit_row_r <= row_r;
          emit_col_r <= col_r;
          if (col_end) begin
            col_r <= '0;
            row_r <= row_end ? '0 : row_r + ROW_W'(1);
          end else begin
            col_r <= col_r + COL_W'(1);
          end
          if (interior)    state_r <= S_CALC;
          else if (border) state_r <= S_EMIT_BRD;
          else             state_r <= S_IDLE;
        end
        S_CALC: if (lane_done[0]) state_r <= S_EMIT_INT;
        S_EMIT_INT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_row_r     <= emit_row_r - ROW_W'(1);
            o_col_r     <= emit_col_r - COL_W'(1);
            o_pix_r     <= {lane_res[2], lane_res[1], lane_res[0]};
            o_last_r    <= !border_r;
            state_r     <= border_r ? S_EMIT_BRD : S_IDLE;
          end else begin
            out_valid_r <= out_valid_r;
          end
        end
        S_EMIT_BRD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_row_r     <= emit_row_r;
            o_col_r     <= emit_col_r;
            o_pix_r     <= pix_r;
            o_last_r    <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            out_valid_r <= out_valid_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_pix.valid       = out_valid_r;
  assign out_pix.out_row     = o_row_r;
  assign out_pix.out_column  = o_col_r;
  assign out_pix.out_red     = o_pix_r[7:0];
  assign out_pix.out_green   = o_pix_r[15:8];
  assign out_pix.out_blue    = o_pix_r[23:16];
  assign out_pix.last_of_run = o_last_r;

  // the three lanes run in lockstep
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
    else $error("channel lanes out of step");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> (state_r == S_CALC))
    else $error("lane finished outside calc");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_RD))
    else $error("accepted item not read");

endmodule
